FILE: hw/rtl/dces_pkg.sv
// ----------------------------------------------------------------------------
// dces_pkg: shared types, constants and microcode for the DC motor step unit
// Holds the item structs, the coefficient set, the control word layout and
// the read-only microprogram that the sequencer walks through.
// ----------------------------------------------------------------------------
package dces_pkg;

    // Field and datapath widths.
    localparam int VAL_W     = 32;              // state, input and output values
    localparam int COEF_W    = 31;              // configuration coefficients
    localparam int PROD_W    = VAL_W + COEF_W;  // one 32 x 31 partial product
    localparam int SUM_W     = 58;              // exact sums, capped product plus state
    localparam int Q_W       = SUM_W - 1;       // magnitude of a capped gain product
    localparam int PC_W      = 4;
    localparam int UC_DEPTH  = 1 << PC_W;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RESISTANCE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACK_EMF   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TORQUE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRICTION   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_IND   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_INER  = 3'd5;

    // Input and result items.
    typedef struct packed {
        logic signed [VAL_W-1:0] voltage;
        logic signed [VAL_W-1:0] load_torque;
        logic                    clear;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] current;
        logic signed [VAL_W-1:0] speed;
        logic                    saturated;
    } t_out_item;

    // Motor coefficients as held in the configuration registers.
    typedef struct packed {
        logic [COEF_W-1:0] resistance;
        logic [COEF_W-1:0] back_emf;
        logic [COEF_W-1:0] torque;
        logic [COEF_W-1:0] friction;
        logic [COEF_W-1:0] step_ind;
        logic [COEF_W-1:0] step_iner;
    } t_coefs;

    // Multiplier operand A: state magnitudes or a half of the accumulator magnitude.
    typedef enum logic [1:0] {
        MA_CUR,
        MA_SPD,
        MA_ACC_LO,
        MA_ACC_HI
    } t_mul_a;

    // Multiplier operand B: one of the coefficients.
    typedef enum logic [2:0] {
        CF_RES,
        CF_KE,
        CF_KT,
        CF_FRIC,
        CF_DTL,
        CF_DTJ
    } t_coef_sel;

    // Accumulator operations.
    typedef enum logic [2:0] {
        ACC_NOP,
        ACC_LD_U,
        ACC_LD_NTL,
        ACC_ADD_P,
        ACC_SUB_P,
        ACC_ADD_Q_CUR,
        ACC_ADD_Q_SPD
    } t_acc_op;

    // Gain product assembly: keep the low half, then fold in the high half.
    typedef enum logic [1:0] {
        Q_NOP,
        Q_LO,
        Q_CAP
    } t_q_op;

    // Result stores.
    typedef enum logic [1:0] {
        ST_NOP,
        ST_NI,
        ST_OUT,
        ST_CLR
    } t_st_op;

    // Sequencing.
    typedef enum logic [1:0] {
        SQ_NEXT,
        SQ_JMP_CLR,
        SQ_DONE
    } t_seq_op;

    typedef struct packed {
        logic      mul_en;
        t_mul_a    mul_a;
        t_coef_sel mul_b;
        t_acc_op   acc_op;
        t_q_op     q_op;
        t_st_op    st_op;
        t_seq_op   seq;
    } t_ctrl;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic clear;
        logic out_blocked;
    } t_stat;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

    localparam t_ctrl CTRL_NOP = '{1'b0, MA_CUR, CF_RES, ACC_NOP, Q_NOP, ST_NOP, SQ_NEXT};

    localparam logic [PC_W-1:0] UC_START = 4'd0;
    localparam logic [PC_W-1:0] UC_CLEAR = 4'd15;

    // Microprogram. A product issued in one step is in the product register
    // for the next step, so issue and use of products overlap.
    //        mul   A          B        acc            q      store   seq
    localparam t_ctrl UCODE [UC_DEPTH] = '{
        // Current error: u - R*i - Ke*w. A clear item jumps straight to the clear step.
        '{1'b1, MA_CUR,    CF_RES,  ACC_LD_U,      Q_NOP, ST_NOP, SQ_JMP_CLR},
        '{1'b1, MA_SPD,    CF_KE,   ACC_SUB_P,     Q_NOP, ST_NOP, SQ_NEXT},
        '{1'b0, MA_CUR,    CF_RES,  ACC_SUB_P,     Q_NOP, ST_NOP, SQ_NEXT},
        // Current gain product in two halves, then the new current.
        '{1'b1, MA_ACC_LO, CF_DTL,  ACC_NOP,       Q_NOP, ST_NOP, SQ_NEXT},
        '{1'b1, MA_ACC_HI, CF_DTL,  ACC_NOP,       Q_LO,  ST_NOP, SQ_NEXT},
        '{1'b0, MA_CUR,    CF_RES,  ACC_NOP,       Q_CAP, ST_NOP, SQ_NEXT},
        '{1'b0, MA_CUR,    CF_RES,  ACC_ADD_Q_CUR, Q_NOP, ST_NOP, SQ_NEXT},
        // Park the new current; speed error: Kt*i - B*w - Tload.
        '{1'b1, MA_CUR,    CF_KT,   ACC_LD_NTL,    Q_NOP, ST_NI,  SQ_NEXT},
        '{1'b1, MA_SPD,    CF_FRIC, ACC_ADD_P,     Q_NOP, ST_NOP, SQ_NEXT},
        '{1'b0, MA_CUR,    CF_RES,  ACC_SUB_P,     Q_NOP, ST_NOP, SQ_NEXT},
        // Speed gain product in two halves, then the new speed.
        '{1'b1, MA_ACC_LO, CF_DTJ,  ACC_NOP,       Q_NOP, ST_NOP, SQ_NEXT},
        '{1'b1, MA_ACC_HI, CF_DTJ,  ACC_NOP,       Q_LO,  ST_NOP, SQ_NEXT},
        '{1'b0, MA_CUR,    CF_RES,  ACC_NOP,       Q_CAP, ST_NOP, SQ_NEXT},
        '{1'b0, MA_CUR,    CF_RES,  ACC_ADD_Q_SPD, Q_NOP, ST_NOP, SQ_NEXT},
        // Commit state and present the result.
        '{1'b0, MA_CUR,    CF_RES,  ACC_NOP,       Q_NOP, ST_OUT, SQ_DONE},
        // Clear: zero the state and present a zero result.
        '{1'b0, MA_CUR,    CF_RES,  ACC_NOP,       Q_NOP, ST_CLR, SQ_DONE}
    };

endpackage

FILE: hw/rtl/dces_sequencer.sv
// ----------------------------------------------------------------------------
// dces_sequencer: step counter and microcode fetch
// Accepts an input item when idle, walks the microprogram one control word
// per cycle, and holds the final step while the last result is stalled.
// ----------------------------------------------------------------------------
module dces_sequencer
    import dces_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output logic  o_in_accept,
    output t_ctrl o_ctrl
);

    t_seq_state      r_state;
    t_seq_state      n_state;
    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_ctrl           rom_word;
    logic            step_hold;

    // Current control word; a store step waits while the last result is stalled.
    assign rom_word  = UCODE[r_pc];
    assign step_hold = (rom_word.st_op inside {ST_OUT, ST_CLR}) && i_stat.out_blocked;

    // Next state and step counter.
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        unique case (r_state)
            SEQ_IDLE: begin
                if (i_in_valid) begin
                    n_state = SEQ_RUN;
                    n_pc    = UC_START;
                end
            end
            SEQ_RUN: begin
                if (!step_hold) begin
                    unique case (rom_word.seq)
                        SQ_NEXT:    n_pc = PC_W'(r_pc + 1'b1);
                        SQ_JMP_CLR: n_pc = i_stat.clear ? UC_CLEAR : PC_W'(r_pc + 1'b1);
                        SQ_DONE:    n_state = SEQ_IDLE;
                        default:    n_pc = r_pc;
                    endcase
                end
            end
            default: n_state = SEQ_IDLE;
        endcase
    end

    // Handshake and control word issue.
    always_comb begin
        o_in_stall  = 1'b1;
        o_in_accept = 1'b0;
        o_ctrl      = CTRL_NOP;
        unique case (r_state)
            SEQ_IDLE: begin
                o_in_stall  = 1'b0;
                o_in_accept = i_in_valid;
            end
            SEQ_RUN: begin
                if (!step_hold) begin
                    o_ctrl = rom_word;
                end
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
            r_pc    <= UC_START;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

endmodule

FILE: hw/rtl/dces_datapath.sv
// ----------------------------------------------------------------------------
// dces_datapath: shared multiplier, accumulator and state registers
// Executes the control words of the sequencer: one 32 x 31 product per
// cycle, exact wide accumulation, capped gain products and saturation.
// ----------------------------------------------------------------------------
module dces_datapath
    import dces_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ctrl     i_ctrl,
    input  logic      i_in_accept,
    input  t_in_item  i_in_data,
    input  t_coefs    i_coefs,
    input  logic      i_out_stall,
    output t_stat     o_stat,
    output logic      o_out_valid,
    output t_out_item o_out_data
);

    // The high partial product is weighted 2^32 before the fraction shift.
    localparam int HI_SHIFT = VAL_W - FRAC_BITS;
    localparam logic [PROD_W-1:0] HI_LIMIT = PROD_W'(1) << (Q_W - 1 - HI_SHIFT);
    localparam logic [SUM_W-1:0]  Q_CAP_SUM = SUM_W'(1) << (Q_W - 1);
    localparam logic [Q_W-1:0]    Q_CAP_VAL = Q_W'(1) << (Q_W - 1);
    localparam logic signed [SUM_W-1:0] SAT_MAX =
        $signed({{(SUM_W - VAL_W + 1){1'b0}}, {(VAL_W - 1){1'b1}}});
    localparam logic signed [SUM_W-1:0] SAT_MIN =
        $signed({{(SUM_W - VAL_W + 1){1'b1}}, {(VAL_W - 1){1'b0}}});

    // Latched item and working registers.
    logic signed [VAL_W-1:0] r_u;
    logic signed [VAL_W-1:0] r_tl;
    logic                    r_clear;
    logic signed [VAL_W-1:0] r_cur;
    logic signed [VAL_W-1:0] r_spd;
    logic signed [SUM_W-1:0] r_acc;
    logic signed [SUM_W-1:0] n_acc;
    logic [PROD_W-1:0]       r_prod;
    logic [PROD_W-1:0]       n_prod;
    logic                    r_pneg;
    logic                    r_qneg;
    logic [Q_W-1:0]          r_q;
    logic [Q_W-1:0]          n_q;
    logic signed [VAL_W-1:0] r_ni;
    logic                    r_ni_clip;
    logic                    r_out_valid;
    t_out_item               r_out;

    logic [VAL_W-1:0]        cur_mag;
    logic [VAL_W-1:0]        spd_mag;
    logic [SUM_W-1:0]        acc_mag;
    logic [VAL_W-1:0]        mul_a;
    logic                    mul_sign;
    logic [COEF_W-1:0]       mul_b;
    logic [PROD_W-1:0]       p_shift;
    logic [SUM_W-1:0]        p_mag;
    logic signed [SUM_W-1:0] p_signed;
    logic [SUM_W-1:0]        hi_sh;
    logic [SUM_W-1:0]        q_sum;
    logic signed [SUM_W-1:0] q_ext;
    logic signed [SUM_W-1:0] q_signed;
    logic signed [SUM_W-1:0] u_ext;
    logic signed [SUM_W-1:0] tl_ext;
    logic signed [SUM_W-1:0] cur_ext;
    logic signed [SUM_W-1:0] spd_ext;
    logic                    sat_hi;
    logic                    sat_lo;
    logic                    sat_clip;
    logic signed [VAL_W-1:0] sat_val;

    // Magnitudes of the signed operands.
    assign cur_mag = r_cur[VAL_W-1] ? $unsigned(-r_cur) : $unsigned(r_cur);
    assign spd_mag = r_spd[VAL_W-1] ? $unsigned(-r_spd) : $unsigned(r_spd);
    assign acc_mag = r_acc[SUM_W-1] ? $unsigned(-r_acc) : $unsigned(r_acc);

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a    = cur_mag;
        mul_sign = 1'b0;
        unique case (i_ctrl.mul_a)
            MA_CUR: begin
                mul_a    = cur_mag;
                mul_sign = r_cur[VAL_W-1];
            end
            MA_SPD: begin
                mul_a    = spd_mag;
                mul_sign = r_spd[VAL_W-1];
            end
            MA_ACC_LO: mul_a = acc_mag[VAL_W-1:0];
            MA_ACC_HI: mul_a = {{(2 * VAL_W - SUM_W){1'b0}}, acc_mag[SUM_W-1:VAL_W]};
        endcase
    end

    always_comb begin
        unique case (i_ctrl.mul_b)
            CF_RES:  mul_b = i_coefs.resistance;
            CF_KE:   mul_b = i_coefs.back_emf;
            CF_KT:   mul_b = i_coefs.torque;
            CF_FRIC: mul_b = i_coefs.friction;
            CF_DTL:  mul_b = i_coefs.step_ind;
            CF_DTJ:  mul_b = i_coefs.step_iner;
            default: mul_b = '0;
        endcase
    end

    assign n_prod = {{COEF_W{1'b0}}, mul_a} * {{VAL_W{1'b0}}, mul_b};

    // Coefficient term: magnitude shifted down (truncates toward zero), then signed.
    assign p_shift  = r_prod >> FRAC_BITS;
    assign p_mag    = p_shift[SUM_W-1:0];
    assign p_signed = r_pneg ? -$signed(p_mag) : $signed(p_mag);

    // Gain product: fold the high half onto the low half and cap the magnitude.
    assign hi_sh = SUM_W'(r_prod << HI_SHIFT);
    assign q_sum = hi_sh + {1'b0, r_q};

    always_comb begin
        unique case (i_ctrl.q_op)
            Q_NOP: n_q = r_q;
            Q_LO:  n_q = p_shift[Q_W-1:0];
            Q_CAP: n_q = ((r_prod >= HI_LIMIT) || (q_sum > Q_CAP_SUM)) ? Q_CAP_VAL
                                                                       : q_sum[Q_W-1:0];
            default: n_q = r_q;
        endcase
    end

    assign q_ext    = $signed({1'b0, r_q});
    assign q_signed = r_qneg ? -q_ext : q_ext;

    // Sign extension of the narrow values.
    assign u_ext   = $signed({{(SUM_W - VAL_W){r_u[VAL_W-1]}}, r_u});
    assign tl_ext  = $signed({{(SUM_W - VAL_W){r_tl[VAL_W-1]}}, r_tl});
    assign cur_ext = $signed({{(SUM_W - VAL_W){r_cur[VAL_W-1]}}, r_cur});
    assign spd_ext = $signed({{(SUM_W - VAL_W){r_spd[VAL_W-1]}}, r_spd});

    // Accumulator.
    always_comb begin
        unique case (i_ctrl.acc_op)
            ACC_NOP:       n_acc = r_acc;
            ACC_LD_U:      n_acc = u_ext;
            ACC_LD_NTL:    n_acc = -tl_ext;
            ACC_ADD_P:     n_acc = r_acc + p_signed;
            ACC_SUB_P:     n_acc = r_acc - p_signed;
            ACC_ADD_Q_CUR: n_acc = cur_ext + q_signed;
            ACC_ADD_Q_SPD: n_acc = spd_ext + q_signed;
            default:       n_acc = r_acc;
        endcase
    end

    // Saturation of the accumulator to the 32-bit range.
    assign sat_hi   = r_acc > SAT_MAX;
    assign sat_lo   = r_acc < SAT_MIN;
    assign sat_clip = sat_hi || sat_lo;
    assign sat_val  = sat_hi ? SAT_MAX[VAL_W-1:0] :
                      sat_lo ? SAT_MIN[VAL_W-1:0] : r_acc[VAL_W-1:0];

    // Motor state and result handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= '0;
            r_spd       <= '0;
            r_out_valid <= 1'b0;
            r_clear     <= 1'b0;
        end else begin
            if (i_in_accept) begin
                r_clear <= i_in_data.clear;
            end
            unique case (i_ctrl.st_op)
                ST_OUT: begin
                    r_cur <= r_ni;
                    r_spd <= sat_val;
                end
                ST_CLR: begin
                    r_cur <= '0;
                    r_spd <= '0;
                end
                default: begin
                    r_cur <= r_cur;
                end
            endcase
            if (i_ctrl.st_op inside {ST_OUT, ST_CLR}) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers and result payload.
    always_ff @(posedge i_clk) begin
        if (i_in_accept) begin
            r_u  <= i_in_data.voltage;
            r_tl <= i_in_data.load_torque;
        end
        if (i_ctrl.mul_en) begin
            r_prod <= n_prod;
            r_pneg <= mul_sign;
            if (i_ctrl.mul_a == MA_ACC_LO) begin
                r_qneg <= r_acc[SUM_W-1];
            end
        end
        r_acc <= n_acc;
        r_q   <= n_q;
        unique case (i_ctrl.st_op)
            ST_NI: begin
                r_ni      <= sat_val;
                r_ni_clip <= sat_clip;
            end
            ST_OUT: begin
                r_out.current   <= r_ni;
                r_out.speed     <= sat_val;
                r_out.saturated <= r_ni_clip || sat_clip;
            end
            ST_CLR: begin
                r_out <= '0;
            end
            default: begin
                r_ni <= r_ni;
            end
        endcase
    end

    assign o_stat.clear       = r_clear;
    assign o_stat.out_blocked = r_out_valid && i_out_stall;
    assign o_out_valid        = r_out_valid;
    assign o_out_data         = r_out;

endmodule

FILE: hw/rtl/dc_motor_euler_step_unit.sv
// ----------------------------------------------------------------------------
// dc_motor_euler_step_unit: DC motor plant, one forward Euler step per item
// Keeps armature current and shaft speed in signed fixed point and advances
// both from their old values on each stepping item; a clear item zeroes them.
//
//   Channel | Direction | Handshake        | Payload
//   --------+-----------+------------------+--------------------------------
//   in      | input     | valid / stall    | voltage, load_torque, clear
//   out     | output    | valid / stall    | current, speed, saturated
//   cfg     | input     | valid / ready    | register index, write data
//
// After acceptance a stepping item walks 15 microcode steps and the sequencer
// returns to idle for the next acceptance, paced by eight passes through one
// shared 32 x 31 multiplier (four coefficient products, and two gain products
// taken in two halves each). A clear item runs only the first and the clear
// steps. The result register lets the next item be accepted while a result
// still waits; the final step holds only while that result is stalled. Reset
// zeroes the state and all coefficients; there is no clearing pass.
// ----------------------------------------------------------------------------
module dc_motor_euler_step_unit
    import dces_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [VAL_W-1:0]     i_cfg_data
);

    t_coefs r_coefs;
    t_ctrl  ctrl;
    t_stat  stat;
    logic   in_accept;

    // Configuration registers; writes to an unknown index are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_RESISTANCE: r_coefs.resistance <= i_cfg_data[COEF_W-1:0];
                CFG_BACK_EMF:   r_coefs.back_emf   <= i_cfg_data[COEF_W-1:0];
                CFG_TORQUE:     r_coefs.torque     <= i_cfg_data[COEF_W-1:0];
                CFG_FRICTION:   r_coefs.friction   <= i_cfg_data[COEF_W-1:0];
                CFG_STEP_IND:   r_coefs.step_ind   <= i_cfg_data[COEF_W-1:0];
                CFG_STEP_INER:  r_coefs.step_iner  <= i_cfg_data[COEF_W-1:0];
                default:        r_coefs <= r_coefs;
            endcase
        end
    end

    // Step counter and microcode.
    dces_sequencer u_sequencer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_stat      (stat),
        .o_in_accept (in_accept),
        .o_ctrl      (ctrl)
    );

    // Arithmetic and state.
    dces_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_in_accept (in_accept),
        .i_in_data   (i_in_data),
        .i_coefs     (r_coefs),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
